@@ rtl/bcc_pkg.sv @@
// Shared types, constants and helpers for the balance robot cascade controller.
// No dependencies; used by every module in rtl/.
package bcc_pkg;

	localparam int ACC_W = 60;
	localparam int MPL_W = 16;

	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic [MPL_W-1:0]        mpl_t;
	typedef logic signed [19:0]      bal_t;
	typedef logic signed [33:0]      vel_t;
	typedef logic signed [19:0]      trn_t;
	typedef logic signed [35:0]      mix_t;
	typedef logic signed [11:0]      drv_t;
	typedef logic signed [39:0]      filt_t;
	typedef logic signed [31:0]      integ_t;
	typedef logic signed [41:0]      isum_t;
	typedef logic [10:0]             cmp_t;

	typedef struct packed {
		logic signed [15:0] tilt_angle;
		logic signed [15:0] tilt_rate;
		logic signed [15:0] turn_rate;
		logic signed [15:0] left_speed;
		logic signed [15:0] right_speed;
		logic [6:0]         line_center;
		logic [11:0]        line_contrast;
		logic               stop_key;
	} meas_t;

	typedef struct packed {
		drv_t left_drive;
		drv_t right_drive;
		cmp_t left_compare_a;
		cmp_t left_compare_b;
		cmp_t right_compare_a;
		cmp_t right_compare_b;
		logic drive_off;
	} drive_t;

	typedef struct packed {
		logic go;
		logic keep;
		acc_t init;
		acc_t mcand;
		mpl_t mplier;
	} mac_cmd_t;

	localparam logic [2:0] REG_BALANCE_OFFSET = 3'd0;
	localparam logic [2:0] REG_BALANCE_KP     = 3'd1;
	localparam logic [2:0] REG_BALANCE_KD     = 3'd2;
	localparam logic [2:0] REG_VELOCITY_KP    = 3'd3;
	localparam logic [2:0] REG_VELOCITY_KI    = 3'd4;
	localparam logic [2:0] REG_TURN_KP        = 3'd5;
	localparam logic [2:0] REG_TURN_KD        = 3'd6;
	localparam logic [2:0] REG_TILT_LIMIT     = 3'd7;

	// 0.8 and 0.2 in Q16
	localparam mpl_t FILT_KEEP = 16'd52429;
	localparam mpl_t FILT_NEW  = 16'd13107;

	localparam acc_t   FILT_MAX       = 60'sh7F_FFFF_FFFF;
	localparam acc_t   FILT_MIN       = -60'sh80_0000_0000;
	localparam isum_t  INTEG_BIAS     = 42'sd393216;
	localparam isum_t  INTEG_LIM      = 42'sd327680000;
	localparam logic [11:0] CONTRAST_LIMIT = 12'd310;
	localparam trn_t   TURN_FORCED    = 20'sd1800;
	localparam logic signed [7:0] LINE_HALF = 8'sd64;
	localparam cmp_t   PWM_PERIOD     = 11'd2000;
	localparam mix_t   DRIVE_LIMIT    = 36'sd2000;

	// arithmetic shift right rounding toward zero
	function automatic acc_t shr_trunc(acc_t x, int n);
		acc_t bias;
		bias = x[ACC_W-1] ? ((acc_t'(1) <<< n) - acc_t'(1)) : '0;
		return (x + bias) >>> n;
	endfunction

	function automatic drv_t clamp_drive(mix_t x);
		mix_t y;
		if (x > DRIVE_LIMIT)
			y = DRIVE_LIMIT;
		else if (x < -DRIVE_LIMIT)
			y = -DRIVE_LIMIT;
		else
			y = x;
		return y[11:0];
	endfunction

endpackage

@@ rtl/bcc_serial_mac.sv @@
// Bit-serial shift-add multiply-accumulate unit: one multiplier bit per cycle.
// Depends on bcc_pkg.
module bcc_serial_mac (
	input  logic               clk,
	input  logic               arst_n,
	input  bcc_pkg::mac_cmd_t  cmd,
	output bcc_pkg::acc_t      acc,
	output logic               busy
);

	bcc_pkg::acc_t acc_q;
	bcc_pkg::acc_t mcand_q;
	bcc_pkg::mpl_t mplier_q;
	logic          busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (cmd.go) begin
			busy_q <= (cmd.mplier != '0);
		end else if (busy_q) begin
			busy_q <= (mplier_q[bcc_pkg::MPL_W-1:1] != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.go) begin
			acc_q    <= cmd.keep ? acc_q : cmd.init;
			mcand_q  <= cmd.mcand;
			mplier_q <= cmd.mplier;
		end else if (busy_q) begin
			if (mplier_q[0])
				acc_q <= acc_q + mcand_q;
			mcand_q  <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign acc  = acc_q;
	assign busy = busy_q;

`ifndef SYNTHESIS
	a_zero_mplier_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.go && cmd.mplier == '0 |=> !busy_q)
		else $error("serial mac busy after zero multiplier");
	a_mplier_runs: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.go && cmd.mplier != '0 |=> busy_q)
		else $error("serial mac did not start");
	a_busy_has_bits: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> mplier_q != '0)
		else $error("serial mac busy with empty multiplier");
`endif

endmodule

@@ rtl/bcc_drive_map.sv @@
// Maps the two clamped wheel mixes onto complementary PWM compare pairs, all zero when off.
// Depends on bcc_pkg.
module bcc_drive_map (
	input  bcc_pkg::drv_t   mix_l,
	input  bcc_pkg::drv_t   mix_r,
	input  logic            off,
	output bcc_pkg::drive_t drive
);

	bcc_pkg::drv_t mag_l;
	bcc_pkg::drv_t mag_r;
	bcc_pkg::cmp_t cmp_l;
	bcc_pkg::cmp_t cmp_r;

	always_comb begin
		mag_l = mix_l[11] ? -mix_l : mix_l;
		mag_r = mix_r[11] ? -mix_r : mix_r;
		cmp_l = bcc_pkg::PWM_PERIOD - mag_l[10:0];
		cmp_r = bcc_pkg::PWM_PERIOD - mag_r[10:0];

		drive.left_drive  = mix_l;
		drive.right_drive = mix_r;
		drive.drive_off   = off;
		if (off) begin
			drive.left_compare_a  = '0;
			drive.left_compare_b  = '0;
			drive.right_compare_a = '0;
			drive.right_compare_b = '0;
		end else begin
			if (mix_l > 12'sd0) begin
				drive.left_compare_a = bcc_pkg::PWM_PERIOD;
				drive.left_compare_b = cmp_l;
			end else begin
				drive.left_compare_a = cmp_l;
				drive.left_compare_b = bcc_pkg::PWM_PERIOD;
			end
			if (mix_r > 12'sd0) begin
				drive.right_compare_a = cmp_r;
				drive.right_compare_b = bcc_pkg::PWM_PERIOD;
			end else begin
				drive.right_compare_a = bcc_pkg::PWM_PERIOD;
				drive.right_compare_b = cmp_r;
			end
		end
	end

endmodule

@@ rtl/balance_robot_cascade_controller.sv @@
// Balance robot cascade controller top level: sequencer, state and config registers.
// Depends on bcc_pkg, bcc_serial_mac and bcc_drive_map.

// One measurement beat in gives one drive beat out. All eight gain products run
// on a single bit-serial multiplier that consumes one gain bit per cycle, so the
// time per product grows with the bit length of that product's gain, which is
// 16 and 14 bits for the fixed filter constants. A new measurement beat is taken
// once the previous item has been handed to the output register, which holds its
// drive beat until taken. Configuration writes are always ready and take effect
// at once, so a write during an item changes the products it has yet to issue.
module balance_robot_cascade_controller (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            meas_valid,
	output logic            meas_stall,
	input  bcc_pkg::meas_t  meas,
	output logic            cmd_valid,
	input  logic            cmd_stall,
	output bcc_pkg::drive_t cmd,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [2:0]      cfg_index,
	input  logic [15:0]     cfg_data
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_ISSUE = 3'd1;
	localparam logic [2:0] ST_WAIT  = 3'd2;
	localparam logic [2:0] ST_MIX   = 3'd3;
	localparam logic [2:0] ST_OUT   = 3'd4;

	localparam logic [2:0] STEP_BAL_A = 3'd0;
	localparam logic [2:0] STEP_BAL_B = 3'd1;
	localparam logic [2:0] STEP_FLT_A = 3'd2;
	localparam logic [2:0] STEP_FLT_B = 3'd3;
	localparam logic [2:0] STEP_VEL_A = 3'd4;
	localparam logic [2:0] STEP_VEL_B = 3'd5;
	localparam logic [2:0] STEP_TRN_A = 3'd6;
	localparam logic [2:0] STEP_TRN_B = 3'd7;

	logic [2:0] state_q;
	logic [2:0] step_q;

	logic signed [15:0] offset_q;
	logic [9:0]         bkp_q;
	logic [9:0]         bkd_q;
	logic [7:0]         vkp_q;
	logic [9:0]         vki_q;
	logic [7:0]         tkp_q;
	logic [9:0]         tkd_q;
	logic [14:0]        limit_q;

	bcc_pkg::meas_t  meas_q;
	logic            stop_q;
	logic            off_q;
	bcc_pkg::filt_t  filt_q;
	bcc_pkg::integ_t integ_q;
	bcc_pkg::bal_t   bal_q;
	bcc_pkg::vel_t   vel_q;
	bcc_pkg::trn_t   turn_q;
	bcc_pkg::drv_t   mix_l_q;
	bcc_pkg::drv_t   mix_r_q;
	bcc_pkg::drive_t cmd_q;
	logic            cmd_valid_q;

	bcc_pkg::mac_cmd_t mac_cmd;
	bcc_pkg::acc_t     mac_acc;
	logic              mac_busy;
	bcc_pkg::drive_t   map_out;

	logic               meas_take;
	logic               stop_next;
	logic signed [16:0] tilt_ext;
	logic signed [16:0] limit_ext;
	logic signed [16:0] tilt_err;
	logic signed [16:0] speed_sum;
	logic signed [7:0]  line_err;
	bcc_pkg::acc_t      bal_full;
	bcc_pkg::acc_t      vel_full;
	bcc_pkg::acc_t      trn_full;
	bcc_pkg::filt_t     filt_sat;
	bcc_pkg::isum_t     integ_sum;
	bcc_pkg::integ_t    integ_sat;
	bcc_pkg::mix_t      sum_l;
	bcc_pkg::mix_t      sum_r;
	logic               out_free;

	bcc_serial_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mac_cmd),
		.acc    (mac_acc),
		.busy   (mac_busy)
	);

	bcc_drive_map u_map (
		.mix_l (mix_l_q),
		.mix_r (mix_r_q),
		.off   (off_q),
		.drive (map_out)
	);

	assign meas_stall = (state_q != ST_IDLE);
	assign meas_take  = meas_valid && !meas_stall;
	assign cfg_ready  = 1'b1;
	assign cmd_valid  = cmd_valid_q;
	assign cmd        = cmd_q;
	assign out_free   = !cmd_valid_q || !cmd_stall;

	always_comb begin
		stop_next = stop_q ^ meas.stop_key;
		tilt_ext  = 17'(meas.tilt_angle);
		limit_ext = signed'({2'b00, limit_q});
		tilt_err  = 17'(meas_q.tilt_angle) - 17'(offset_q);
		speed_sum = 17'(meas_q.left_speed) + 17'(meas_q.right_speed);
		line_err  = bcc_pkg::LINE_HALF - signed'({1'b0, meas_q.line_center});

		bal_full = bcc_pkg::shr_trunc(mac_acc, 8);
		vel_full = bcc_pkg::shr_trunc(mac_acc, 24);
		trn_full = bcc_pkg::shr_trunc(mac_acc, 8);

		if (mac_acc > bcc_pkg::FILT_MAX)
			filt_sat = bcc_pkg::FILT_MAX[39:0];
		else if (mac_acc < bcc_pkg::FILT_MIN)
			filt_sat = bcc_pkg::FILT_MIN[39:0];
		else
			filt_sat = mac_acc[39:0];

		integ_sum = 42'(integ_q) + 42'(filt_q) + bcc_pkg::INTEG_BIAS;
		if (integ_sum > bcc_pkg::INTEG_LIM)
			integ_sat = bcc_pkg::INTEG_LIM[31:0];
		else if (integ_sum < -bcc_pkg::INTEG_LIM)
			integ_sat = -bcc_pkg::INTEG_LIM[31:0];
		else
			integ_sat = integ_sum[31:0];

		sum_l = 36'(bal_q) + 36'(vel_q) - 36'(turn_q);
		sum_r = 36'(bal_q) + 36'(vel_q) + 36'(turn_q);
	end

	// multiplier command for the current product
	always_comb begin
		mac_cmd = '0;
		if (state_q == ST_ISSUE) begin
			mac_cmd.go = 1'b1;
			case (step_q)
				STEP_BAL_A: begin
					mac_cmd.mcand  = bcc_pkg::acc_t'(tilt_err);
					mac_cmd.mplier = bcc_pkg::mpl_t'(bkp_q);
				end
				STEP_BAL_B: begin
					mac_cmd.keep   = 1'b1;
					mac_cmd.mcand  = bcc_pkg::acc_t'(meas_q.tilt_rate);
					mac_cmd.mplier = bcc_pkg::mpl_t'(bkd_q);
				end
				STEP_FLT_A: begin
					mac_cmd.mcand  = bcc_pkg::acc_t'(filt_q);
					mac_cmd.mplier = bcc_pkg::FILT_KEEP;
				end
				STEP_FLT_B: begin
					mac_cmd.init   = mac_acc >>> 16;
					mac_cmd.mcand  = bcc_pkg::acc_t'(speed_sum);
					mac_cmd.mplier = bcc_pkg::FILT_NEW;
				end
				STEP_VEL_A: begin
					mac_cmd.mcand  = bcc_pkg::acc_t'(filt_q) <<< 8;
					mac_cmd.mplier = bcc_pkg::mpl_t'(vkp_q);
				end
				STEP_VEL_B: begin
					mac_cmd.keep   = 1'b1;
					mac_cmd.mcand  = bcc_pkg::acc_t'(integ_q);
					mac_cmd.mplier = bcc_pkg::mpl_t'(vki_q);
				end
				STEP_TRN_A: begin
					mac_cmd.mcand  = bcc_pkg::acc_t'(line_err) <<< 8;
					mac_cmd.mplier = bcc_pkg::mpl_t'(tkp_q);
				end
				STEP_TRN_B: begin
					mac_cmd.keep   = 1'b1;
					mac_cmd.mcand  = -bcc_pkg::acc_t'(meas_q.turn_rate);
					mac_cmd.mplier = bcc_pkg::mpl_t'(tkd_q);
				end
				default: begin
					mac_cmd.keep = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			bkp_q    <= 10'd300;
			bkd_q    <= 10'd215;
			vkp_q    <= 8'd96;
			vki_q    <= 10'd212;
			tkp_q    <= 8'd17;
			tkd_q    <= 10'd0;
			limit_q  <= 15'd10240;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bcc_pkg::REG_BALANCE_OFFSET: offset_q <= cfg_data;
				bcc_pkg::REG_BALANCE_KP:     bkp_q    <= cfg_data[9:0];
				bcc_pkg::REG_BALANCE_KD:     bkd_q    <= cfg_data[9:0];
				bcc_pkg::REG_VELOCITY_KP:    vkp_q    <= cfg_data[7:0];
				bcc_pkg::REG_VELOCITY_KI:    vki_q    <= cfg_data[9:0];
				bcc_pkg::REG_TURN_KP:        tkp_q    <= cfg_data[7:0];
				bcc_pkg::REG_TURN_KD:        tkd_q    <= cfg_data[9:0];
				bcc_pkg::REG_TILT_LIMIT:     limit_q  <= cfg_data[14:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STEP_BAL_A;
			stop_q      <= 1'b1;
			filt_q      <= '0;
			integ_q     <= '0;
			cmd_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free)
				cmd_valid_q <= 1'b1;
			else if (cmd_valid_q && !cmd_stall)
				cmd_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (meas_take) begin
						stop_q  <= stop_next;
						step_q  <= STEP_BAL_A;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (step_q == STEP_VEL_A)
						integ_q <= integ_sat;
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (!mac_busy) begin
						if (step_q == STEP_FLT_B)
							filt_q <= filt_sat;
						if (step_q == STEP_VEL_B && off_q)
							integ_q <= '0;
						if (step_q == STEP_TRN_B) begin
							state_q <= ST_MIX;
						end else begin
							step_q  <= step_q + 3'd1;
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_MIX: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (meas_take) begin
			meas_q <= meas;
			off_q  <= stop_next || (tilt_ext > limit_ext) || (tilt_ext < -limit_ext);
		end
		if (state_q == ST_WAIT && !mac_busy) begin
			case (step_q)
				STEP_BAL_B: bal_q <= bal_full[19:0];
				STEP_VEL_B: vel_q <= vel_full[33:0];
				STEP_TRN_B: begin
					if (meas_q.line_contrast > bcc_pkg::CONTRAST_LIMIT)
						turn_q <= bcc_pkg::TURN_FORCED;
					else
						turn_q <= trn_full[19:0];
				end
				default: begin
				end
			endcase
		end
		if (state_q == ST_MIX) begin
			mix_l_q <= bcc_pkg::clamp_drive(sum_l);
			mix_r_q <= bcc_pkg::clamp_drive(sum_r);
		end
		if (state_q == ST_OUT && out_free)
			cmd_q <= map_out;
	end

`ifndef SYNTHESIS
	a_issue_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		mac_cmd.go |-> !mac_busy)
		else $error("product issued while multiplier busy");
	a_off_zero_compares: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid_q && cmd_q.drive_off |-> cmd_q.left_compare_a == '0 &&
			cmd_q.left_compare_b == '0 && cmd_q.right_compare_a == '0 &&
			cmd_q.right_compare_b == '0)
		else $error("compare active with drive off");
`endif

endmodule
